### sv/rmth_pkg.sv
// Shared types, state encodings and the ordering function for the running median block.
package rmth_pkg;

  // Operations that one heap unit carries out on request.
  typedef enum logic {
    HOP_PUSH,
    HOP_REPL
  } heap_op_t;

  // Request from the sequencer to one heap unit.
  typedef struct packed {
    logic               valid;
    heap_op_t           op;
    logic signed [31:0] value;
  } heap_cmd_t;

  // States of the sift engine inside a heap unit.
  typedef enum logic [2:0] {
    HS_IDLE,
    HS_UP_RD,
    HS_UP_CMP,
    HS_DN_RDL,
    HS_DN_RDR,
    HS_DN_CMP
  } heap_state_t;

  // States of the top level sequencer.
  typedef enum logic [1:0] {
    TS_IDLE,
    TS_RUN,
    TS_OUT
  } top_state_t;

  // True when a belongs above b in the heap (max-heap or min-heap order).
  function automatic logic heap_before(logic is_max, logic signed [31:0] a,
                                       logic signed [31:0] b);
    heap_before = is_max ? (a > b) : (a < b);
  endfunction

endpackage

### sv/rmth_heap.sv
// One binary heap in a synchronous memory with a sift-up push and a replace-top sift-down.
module rmth_heap #(
  parameter bit IS_MAX = 1'b1,
  parameter int DEPTH  = 512
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rmth_pkg::heap_cmd_t             cmd_i,
  output logic                            done_o,
  output logic [$clog2(DEPTH + 1) - 1:0]  size_o,
  output logic signed [31:0]              top_o
);

  localparam int SW  = $clog2(DEPTH + 1);
  localparam int IXW = $clog2(2 * DEPTH + 2);
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rmth_pkg::heap_state_t state_r, state_nxt;
  logic [IXW-1:0]        i_r, i_nxt;
  logic signed [31:0]    v_r, v_nxt;
  logic signed [31:0]    lc_r, lc_nxt;
  logic                  hasr_r, hasr_nxt;
  logic [SW-1:0]         size_r, size_nxt;
  logic signed [31:0]    top_r, top_nxt;

  logic signed [31:0]    mem [DEPTH];
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic signed [31:0]    rd_q;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic signed [31:0]    wr_data;

  logic [IXW-1:0]        left_ix;
  logic [IXW-1:0]        size_x;
  logic [IXW-1:0]        best_ix;
  logic signed [31:0]    best_val;

  assign left_ix = {i_r[IXW-2:0], 1'b0};
  assign size_x  = IXW'(size_r);
  assign size_o  = size_r;
  assign top_o   = top_r;

  // Better child of the current node, left wins ties.
  always_comb begin
    best_val = lc_r;
    best_ix  = left_ix;
    if (hasr_r && rmth_pkg::heap_before(IS_MAX, rd_q, lc_r)) begin
      best_val = rd_q;
      best_ix  = left_ix + 1'b1;
    end
  end

  // Sift engine: next state, memory accesses and completion.
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    v_nxt     = v_r;
    lc_nxt    = lc_r;
    hasr_nxt  = hasr_r;
    size_nxt  = size_r;
    top_nxt   = top_r;
    rd_en     = 1'b0;
    rd_addr   = AW'(i_r - 1'b1);
    wr_en     = 1'b0;
    wr_addr   = AW'(i_r - 1'b1);
    wr_data   = v_r;
    done_o    = 1'b0;
    unique case (state_r)
      rmth_pkg::HS_IDLE: begin
        if (cmd_i.valid) begin
          v_nxt = cmd_i.value;
          if (cmd_i.op == rmth_pkg::HOP_PUSH) begin
            size_nxt  = size_r + 1'b1;
            i_nxt     = size_x + 1'b1;
            state_nxt = rmth_pkg::HS_UP_RD;
          end else begin
            i_nxt     = IXW'(1);
            state_nxt = rmth_pkg::HS_DN_RDL;
          end
        end
      end
      rmth_pkg::HS_UP_RD: begin
        if (i_r == IXW'(1)) begin
          wr_en     = 1'b1;
          top_nxt   = v_r;
          done_o    = 1'b1;
          state_nxt = rmth_pkg::HS_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'((i_r >> 1) - 1'b1);
          state_nxt = rmth_pkg::HS_UP_CMP;
        end
      end
      rmth_pkg::HS_UP_CMP: begin
        wr_en = 1'b1;
        if (rmth_pkg::heap_before(IS_MAX, v_r, rd_q)) begin
          wr_data   = rd_q;
          i_nxt     = i_r >> 1;
          state_nxt = rmth_pkg::HS_UP_RD;
        end else begin
          done_o    = 1'b1;
          state_nxt = rmth_pkg::HS_IDLE;
        end
      end
      rmth_pkg::HS_DN_RDL: begin
        if (left_ix > size_x) begin
          wr_en = 1'b1;
          if (i_r == IXW'(1)) begin
            top_nxt = v_r;
          end
          done_o    = 1'b1;
          state_nxt = rmth_pkg::HS_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(left_ix - 1'b1);
          state_nxt = rmth_pkg::HS_DN_RDR;
        end
      end
      rmth_pkg::HS_DN_RDR: begin
        lc_nxt   = rd_q;
        hasr_nxt = (left_ix + 1'b1) <= size_x;
        rd_en    = hasr_nxt;
        rd_addr  = AW'(left_ix);
        state_nxt = rmth_pkg::HS_DN_CMP;
      end
      rmth_pkg::HS_DN_CMP: begin
        wr_en = 1'b1;
        if (rmth_pkg::heap_before(IS_MAX, best_val, v_r)) begin
          wr_data = best_val;
          if (i_r == IXW'(1)) begin
            top_nxt = best_val;
          end
          i_nxt     = best_ix;
          state_nxt = rmth_pkg::HS_DN_RDL;
        end else begin
          if (i_r == IXW'(1)) begin
            top_nxt = v_r;
          end
          done_o    = 1'b1;
          state_nxt = rmth_pkg::HS_IDLE;
        end
      end
      default: begin
        state_nxt = rmth_pkg::HS_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmth_pkg::HS_IDLE;
      size_r  <= '0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
    end
  end

  // Working registers of the sift.
  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    v_r    <= v_nxt;
    lc_r   <= lc_nxt;
    hasr_r <= hasr_nxt;
    top_r  <= top_nxt;
  end

  // Heap memory with one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

endmodule

### sv/running_median_two_heaps_top.sv
// Running lower median over two heaps held in synchronous memories.
// Each request walks the heap levels: a push reads and compares per level, a sift-down reads the
// left child, the right child and then compares; the two heaps run in parallel.
// Throughput: one request at a time; the next is taken at the edge that takes the result.
// A rejected request on a full store returns its result the next cycle and leaves busy low.
// Reset (rst_n low, synchronous) empties both heaps at once; the memories are not cleared.
module running_median_two_heaps_top #(
  parameter int TOTAL_CAPACITY = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_sample_value,
  output logic               out_valid,
  output logic signed [31:0] out_median_value,
  output logic [10:0]        out_value_count,
  output logic               out_overflow_flag
);

  localparam int LCAP = (TOTAL_CAPACITY + 1) / 2;
  localparam int UCAP = TOTAL_CAPACITY / 2;
  localparam int LSW  = $clog2(LCAP + 1);
  localparam int USW  = $clog2(UCAP + 1);
  localparam int CW   = $clog2(TOTAL_CAPACITY + 1);

  rmth_pkg::top_state_t state_r, state_nxt;
  logic [1:0]           pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [31:0]   med_r, med_nxt;
  logic [10:0]          cnt_r, cnt_nxt;
  logic                 ovf_r, ovf_nxt;

  rmth_pkg::heap_cmd_t  cmd_l, cmd_u;
  logic                 done_l, done_u;
  logic [LSW-1:0]       size_l;
  logic [USW-1:0]       size_u;
  logic signed [31:0]   top_l, top_u;
  logic [CW-1:0]        count;
  logic                 lower_ahead;

  // Lower half, max-heap.
  rmth_heap #(.IS_MAX(1'b1), .DEPTH(LCAP)) u_lower (
    .clk(clk), .rst_n(rst_n), .cmd_i(cmd_l), .done_o(done_l), .size_o(size_l), .top_o(top_l)
  );

  // Upper half, min-heap.
  rmth_heap #(.IS_MAX(1'b0), .DEPTH(UCAP)) u_upper (
    .clk(clk), .rst_n(rst_n), .cmd_i(cmd_u), .done_o(done_u), .size_o(size_u), .top_o(top_u)
  );

  assign count       = CW'(size_l) + CW'(size_u);
  assign lower_ahead = CW'(size_l) > CW'(size_u);

  // Sequencer: picks the heap requests for a sample and waits for each heap it started.
  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r & ~{done_u, done_l};
    out_valid_nxt = 1'b0;
    med_nxt       = med_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    cmd_l         = '{valid: 1'b0, op: rmth_pkg::HOP_PUSH, value: in_sample_value};
    cmd_u         = '{valid: 1'b0, op: rmth_pkg::HOP_PUSH, value: in_sample_value};
    unique case (state_r)
      rmth_pkg::TS_IDLE: begin
        if (start) begin
          if (count >= CW'(TOTAL_CAPACITY)) begin
            out_valid_nxt = 1'b1;
            med_nxt       = top_l;
            cnt_nxt       = 11'(count);
            ovf_nxt       = 1'b1;
          end else begin
            ovf_nxt   = 1'b0;
            state_nxt = rmth_pkg::TS_RUN;
            priority if (size_l == '0) begin
              cmd_l.valid = 1'b1;
              pend_nxt    = 2'b01;
            end else if (lower_ahead && (in_sample_value >= top_l)) begin
              cmd_u.valid = 1'b1;
              pend_nxt    = 2'b10;
            end else if (lower_ahead) begin
              // Lower top crosses over, the sample takes its place.
              cmd_l.valid = 1'b1;
              cmd_l.op    = rmth_pkg::HOP_REPL;
              cmd_u.valid = 1'b1;
              cmd_u.value = top_l;
              pend_nxt    = 2'b11;
            end else if ((in_sample_value > top_l) && (in_sample_value > top_u)) begin
              // Upper top crosses over, the sample takes its place.
              cmd_u.valid = 1'b1;
              cmd_u.op    = rmth_pkg::HOP_REPL;
              cmd_l.valid = 1'b1;
              cmd_l.value = top_u;
              pend_nxt    = 2'b11;
            end else begin
              cmd_l.valid = 1'b1;
              pend_nxt    = 2'b01;
            end
          end
        end
      end
      rmth_pkg::TS_RUN: begin
        if (pend_nxt == 2'b00) begin
          state_nxt = rmth_pkg::TS_OUT;
        end
      end
      rmth_pkg::TS_OUT: begin
        out_valid_nxt = 1'b1;
        med_nxt       = top_l;
        cnt_nxt       = 11'(count);
        state_nxt     = rmth_pkg::TS_IDLE;
      end
      default: begin
        state_nxt = rmth_pkg::TS_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmth_pkg::TS_IDLE;
      pend_r      <= 2'b00;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    med_r <= med_nxt;
    cnt_r <= cnt_nxt;
    ovf_r <= ovf_nxt;
  end

  assign busy              = (state_r != rmth_pkg::TS_IDLE);
  assign out_valid         = out_valid_r;
  assign out_median_value  = med_r;
  assign out_value_count   = cnt_r;
  assign out_overflow_flag = ovf_r;

endmodule

### sv/rmth_checker.sv
// Port-level checks for the running median block and their binding to the top level.
module rmth_checker #(
  parameter int TOTAL_CAPACITY = 1024
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [10:0] out_value_count,
  input logic        out_overflow_flag
);

  // An accepted request either starts work or answers at once.
  a_accept_reacts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request neither started work nor answered");

  // Work finishing always shows a result.
  a_done_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // No result appears while work is in progress.
  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && $past(busy)) |-> !out_valid)
    else $error("result shown while busy");

  // A rejected request reports a full store.
  a_overflow_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow_flag) |-> (out_value_count == 11'(TOTAL_CAPACITY)))
    else $error("overflow reported with a count other than capacity");

endmodule

bind running_median_two_heaps_top rmth_checker #(.TOTAL_CAPACITY(TOTAL_CAPACITY)) u_rmth_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_value_count(out_value_count), .out_overflow_flag(out_overflow_flag)
);
